/* src/euler_transform_matrix_unit_macros.svh */
// Assertion macros for the Euler transform matrix unit.
`ifndef EULER_TRANSFORM_MATRIX_UNIT_MACROS_SVH
`define EULER_TRANSFORM_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ETM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etm assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define ETM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etm assertion failed");

`endif

/* src/etm_pkg.sv */
// Types, constants and arithmetic helpers of the Euler transform matrix unit.
`default_nettype none
package etm_pkg;

	localparam int AW = 21;            // angle residual, Q5.16 radians
	localparam int CW = 34;            // sine/cosine and rotation entries, Q4.30
	localparam int DIV_BITS = 36;      // quotient bits of the reciprocal
	localparam int DIVIDEND_BIT = 32;  // dividend is 2^32
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int DIV_PER_STAGE = 3;
	localparam int FRONT_STAGES = DIV_BITS / DIV_PER_STAGE;
	localparam int FLIP_STAGE = CORDIC_STEPS / CORDIC_PER_STAGE + 1;

	localparam logic signed [AW-1:0] PI_Q16      = 21'sd205887;
	localparam logic signed [AW-1:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0]   ONE_Q16     = 32'sd65536;
	localparam logic [31:0]          SAT_MAX     = 32'h7fff_ffff;
	localparam logic [31:0]          SAT_MIN     = 32'h8000_0000;

	localparam logic [1:0] COL_TRANS       = 2'd3;
	localparam logic [1:0] COL_LAST_NORMAL = 2'd2;
	localparam logic [1:0] COL_LAST_MODEL  = 2'd3;

	localparam logic CMD_MODEL  = 1'b0;
	localparam logic CMD_NORMAL = 1'b1;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
	} rot_t;

	typedef struct packed {
		logic [31:0]         rem;
		logic [DIV_BITS-1:0] quo;
	} div_t;

	typedef struct packed {
		logic             cmd;
		logic [2:0]       flip;
		rot_t [2:0]       rot;    // 0: yaw (rot_y), 1: pitch (rot_x), 2: roll (rot_z)
		logic [2:0][31:0] scale;
		logic [2:0][31:0] dmag;   // |scale|
		logic [2:0][31:0] trans;
		div_t [2:0]       dv;
	} front_t;

	function automatic logic signed [AW-1:0] atan_q16(input int i);
		logic signed [AW-1:0] v;
		case (i)
			0:       v = 21'sd51472;
			1:       v = 21'sd30386;
			2:       v = 21'sd16055;
			3:       v = 21'sd8150;
			4:       v = 21'sd4091;
			5:       v = 21'sd2047;
			6:       v = 21'sd1024;
			7:       v = 21'sd512;
			8:       v = 21'sd256;
			9:       v = 21'sd128;
			10:      v = 21'sd64;
			11:      v = 21'sd32;
			12:      v = 21'sd16;
			13:      v = 21'sd8;
			14:      v = 21'sd4;
			default: v = 21'sd2;
		endcase
		return v;
	endfunction

	function automatic rot_t cordic_step(input rot_t a, input int i);
		rot_t r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = a.x >>> i;
		ys = a.y >>> i;
		if (a.z >= 0) begin
			r.x = a.x - ys;
			r.y = a.y + xs;
			r.z = a.z - atan_q16(i);
		end else begin
			r.x = a.x + ys;
			r.y = a.y - xs;
			r.z = a.z + atan_q16(i);
		end
		return r;
	endfunction

	// One restoring division step.
	function automatic div_t div_step(input div_t a, input logic [31:0] d, input logic nbit);
		div_t r;
		logic [32:0] sh;
		sh = {a.rem, nbit};
		if (sh >= {1'b0, d}) begin
			r.rem = 32'(sh - {1'b0, d});
			r.quo = {a.quo[DIV_BITS-2:0], 1'b1};
		end else begin
			r.rem = sh[31:0];
			r.quo = {a.quo[DIV_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	// Q4.30 product, rounded, floor shift.
	function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		p = p + (68'sd1 <<< 29);
		p = p >>> 30;
		return CW'(p);
	endfunction

	// Q16.16 factor times Q4.30 entry, rounded, saturated.
	function automatic logic [31:0] elem(input logic signed [31:0] f,
			input logic signed [CW-1:0] r);
		logic signed [CW+31:0] p;
		p = f * r;
		p = p + (66'sd1 <<< 29);
		p = p >>> 30;
		if (p > $signed({{CW{1'b0}}, SAT_MAX}))
			return SAT_MAX;
		else if (p < $signed({{CW{1'b1}}, SAT_MIN}))
			return SAT_MIN;
		return p[31:0];
	endfunction

endpackage
`default_nettype wire

/* src/etm_if.sv */
// Request and result channel interfaces of the Euler transform matrix unit.
`default_nettype none
interface etm_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [15:0] rot_x;
	logic signed [15:0] rot_y;
	logic signed [15:0] rot_z;
	logic signed [31:0] scale_x;
	logic signed [31:0] scale_y;
	logic signed [31:0] scale_z;
	logic signed [31:0] trans_x;
	logic signed [31:0] trans_y;
	logic signed [31:0] trans_z;

	modport source (output valid, cmd, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z,
		trans_x, trans_y, trans_z, input ready);
	modport sink (input valid, cmd, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z,
		trans_x, trans_y, trans_z, output ready);
endinterface

interface etm_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         column;
	logic signed [31:0] elem_0;
	logic signed [31:0] elem_1;
	logic signed [31:0] elem_2;
	logic signed [31:0] elem_3;
	logic               div_error;
	logic               last;

	modport source (output valid, column, elem_0, elem_1, elem_2, elem_3, div_error, last,
		input ready);
	modport sink (input valid, column, elem_0, elem_1, elem_2, elem_3, div_error, last,
		output ready);
endinterface
`default_nettype wire

/* src/euler_transform_matrix_unit.sv */
// Top level: Euler angles, scale and translation to a column-serial transform matrix.
//
//  channel  dir  handshake     payload
//  item     in   valid/ready   cmd, rot_x/y/z, scale_x/y/z, trans_x/y/z
//  result   out  valid/ready   column, elem_0..3, div_error, last
//
// One request per cycle, while item.ready is high, enters a 16-stage pipeline: input
// fold, 12 stages of CORDIC (two steps each, first 8) beside a restoring reciprocal
// (3 bits each), then 3 stages of products, rotation sums and scaled elements.
// The column serializer sets the rate: four columns per model request, three per normal.
// arst_n clears the valid bits, busy_q and col_q only. A stall at the serializer freezes
// the whole pipeline once stage 15 holds a matrix; nothing is lost or repeated.
`default_nettype none
module euler_transform_matrix_unit
	import etm_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	etm_in_if.sink      item,
	etm_out_if.source   result
);

	logic adv;     // global pipeline enable
	logic take;    // serializer can load a finished matrix

	// ---------------- input stage: angle scaling and quadrant fold ----------------
	front_t front_in;
	logic signed [15:0] ang [3];
	logic signed [AW-1:0] z0 [3];

	assign ang[0] = item.rot_y;
	assign ang[1] = item.rot_x;
	assign ang[2] = item.rot_z;

	always_comb begin
		front_in.cmd      = item.cmd;
		front_in.scale[0] = item.scale_x;
		front_in.scale[1] = item.scale_y;
		front_in.scale[2] = item.scale_z;
		front_in.trans[0] = item.trans_x;
		front_in.trans[1] = item.trans_y;
		front_in.trans[2] = item.trans_z;
		for (int a = 0; a < 3; a++) begin
			z0[a] = {{(AW-19){ang[a][15]}}, ang[a], 3'b000};
			front_in.rot[a].x = CORDIC_GAIN;
			front_in.rot[a].y = '0;
			if (z0[a] > HALF_PI_Q16) begin
				front_in.rot[a].z = z0[a] - PI_Q16;
				front_in.flip[a]  = 1'b1;
			end else if (z0[a] < -HALF_PI_Q16) begin
				front_in.rot[a].z = z0[a] + PI_Q16;
				front_in.flip[a]  = 1'b1;
			end else begin
				front_in.rot[a].z = z0[a];
				front_in.flip[a]  = 1'b0;
			end
			front_in.dmag[a] = front_in.scale[a][31] ? 32'(-front_in.scale[a])
				: front_in.scale[a];
			front_in.dv[a]   = '0;
		end
	end

	// ---------------- front pipeline: CORDIC and reciprocal ----------------
	logic [FRONT_STAGES:0] v_front_s;
	front_t front_s [FRONT_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_front_s[0] <= 1'b0;
		end else if (adv) begin
			v_front_s[0] <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s[0] <= front_in;
		end
	end

	for (genvar g = 1; g <= FRONT_STAGES; g++) begin : g_front
		front_t nxt;

		always_comb begin
			nxt = front_s[g-1];
			for (int a = 0; a < 3; a++) begin
				if (g < FLIP_STAGE) begin
					for (int t = 0; t < CORDIC_PER_STAGE; t++) begin
						nxt.rot[a] = cordic_step(nxt.rot[a], (g-1)*CORDIC_PER_STAGE + t);
					end
				end
				if (g == FLIP_STAGE && nxt.flip[a]) begin
					nxt.rot[a].x = -nxt.rot[a].x;
					nxt.rot[a].y = -nxt.rot[a].y;
				end
				for (int t = 0; t < DIV_PER_STAGE; t++) begin
					nxt.dv[a] = div_step(nxt.dv[a], nxt.dmag[a],
						(DIV_BITS - 1 - ((g-1)*DIV_PER_STAGE + t)) == DIVIDEND_BIT);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_front_s[g] <= 1'b0;
			end else if (adv) begin
				v_front_s[g] <= v_front_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				front_s[g] <= nxt;
			end
		end
	end

	// ---------------- stage 13: column factors and pair products ----------------
	front_t fe;
	assign fe = front_s[FRONT_STAGES];

	logic signed [CW-1:0] c1, s1, c2, s2, c3, s3;
	assign c1 = fe.rot[0].x;
	assign s1 = fe.rot[0].y;
	assign c2 = fe.rot[1].x;
	assign s2 = fe.rot[1].y;
	assign c3 = fe.rot[2].x;
	assign s3 = fe.rot[2].y;

	logic [2:0][31:0] f_nxt;
	logic [2:0]       err_nxt;

	// Model: factor is the scale. Normal: signed, saturated 2^32 / scale.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			err_nxt[j] = 1'b0;
			if (fe.cmd == CMD_MODEL) begin
				f_nxt[j] = fe.scale[j];
			end else if (fe.scale[j] == '0) begin
				f_nxt[j]   = SAT_MAX;
				err_nxt[j] = 1'b1;
			end else if (!fe.scale[j][31]) begin
				f_nxt[j] = (fe.dv[j].quo > DIV_BITS'(SAT_MAX)) ? SAT_MAX
					: fe.dv[j].quo[31:0];
			end else begin
				f_nxt[j] = (fe.dv[j].quo > DIV_BITS'(SAT_MIN)) ? SAT_MIN
					: 32'(-fe.dv[j].quo[31:0]);
			end
		end
	end

	logic v_s13, v_s14, v_s15;
	logic                 cmd_s13;
	logic [2:0]           err_s13;
	logic [2:0][31:0]     f_s13, trans_s13;
	logic signed [CW-1:0] s2_s13, s3_s13;
	logic signed [CW-1:0] c1c3_s13, s1s2_s13, c1s2_s13, c3s1_s13, c1s3_s13;
	logic signed [CW-1:0] c2s3_s13, c2c3_s13, c2s1_s13, c1c2_s13, s1s3_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s13   <= fe.cmd;
			err_s13   <= err_nxt;
			f_s13     <= f_nxt;
			trans_s13 <= fe.trans;
			s2_s13    <= s2;
			s3_s13    <= s3;
			c1c3_s13  <= mulq(c1, c3);
			s1s2_s13  <= mulq(s1, s2);
			c1s2_s13  <= mulq(c1, s2);
			c3s1_s13  <= mulq(c3, s1);
			c1s3_s13  <= mulq(c1, s3);
			c2s3_s13  <= mulq(c2, s3);
			c2c3_s13  <= mulq(c2, c3);
			c2s1_s13  <= mulq(c2, s1);
			c1c2_s13  <= mulq(c1, c2);
			s1s3_s13  <= mulq(s1, s3);
		end
	end

	// ---------------- stage 14: rotation entries r[col][row] ----------------
	logic                        cmd_s14;
	logic [2:0]                  err_s14;
	logic [2:0][31:0]            f_s14, trans_s14;
	logic [2:0][2:0][CW-1:0]     r_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s14      <= cmd_s13;
			err_s14      <= err_s13;
			f_s14        <= f_s13;
			trans_s14    <= trans_s13;
			r_s14[0][0]  <= c1c3_s13 + mulq(s1s2_s13, s3_s13);
			r_s14[0][1]  <= c2s3_s13;
			r_s14[0][2]  <= mulq(c1s2_s13, s3_s13) - c3s1_s13;
			r_s14[1][0]  <= mulq(c3s1_s13, s2_s13) - c1s3_s13;
			r_s14[1][1]  <= c2c3_s13;
			r_s14[1][2]  <= mulq(c1c3_s13, s2_s13) + s1s3_s13;
			r_s14[2][0]  <= c2s1_s13;
			r_s14[2][1]  <= -s2_s13;
			r_s14[2][2]  <= c1c2_s13;
		end
	end

	// ---------------- stage 15: scaled, saturated elements ----------------
	logic                    cmd_s15;
	logic [2:0]              err_s15;
	logic [2:0][31:0]        trans_s15;
	logic [2:0][2:0][31:0]   e_s15;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s15   <= cmd_s14;
			err_s15   <= err_s14;
			trans_s15 <= trans_s14;
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					e_s15[j][k] <= elem(f_s14[j], r_s14[j][k]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s13 <= v_front_s[FRONT_STAGES];
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	// ---------------- column serializer ----------------
	logic                  busy_q;
	logic [1:0]            col_q;
	logic                  cmd_q;
	logic [2:0]            err_q;
	logic [2:0][31:0]      trans_q;
	logic [2:0][2:0][31:0] mat_q;
	logic                  last_col;

	assign last_col = (cmd_q == CMD_NORMAL) ? (col_q == COL_LAST_NORMAL)
		: (col_q == COL_LAST_MODEL);
	assign take = !busy_q || (result.ready && last_col);
	assign adv  = !v_s15 || take;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (v_s15 && take) begin
			busy_q <= 1'b1;
			col_q  <= '0;
		end else if (busy_q && result.ready) begin
			if (last_col) begin
				busy_q <= 1'b0;
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s15 && take) begin
			cmd_q   <= cmd_s15;
			err_q   <= err_s15;
			trans_q <= trans_s15;
			mat_q   <= e_s15;
		end
	end

	always_comb begin
		result.valid  = busy_q;
		result.column = col_q;
		result.last   = last_col;
		if (col_q == COL_TRANS) begin
			result.elem_0    = trans_q[0];
			result.elem_1    = trans_q[1];
			result.elem_2    = trans_q[2];
			result.elem_3    = ONE_Q16;
			result.div_error = 1'b0;
		end else begin
			result.elem_0    = mat_q[col_q][0];
			result.elem_1    = mat_q[col_q][1];
			result.elem_2    = mat_q[col_q][2];
			result.elem_3    = '0;
			result.div_error = err_q[col_q];
		end
	end

	// ---------------- assertions ----------------
`include "euler_transform_matrix_unit_macros.svh"

	`ETM_ASSERT_NXT(a_mid_matrix_holds, busy_q && !last_col, busy_q)
	`ETM_ASSERT_IMP(a_err_normal_only, busy_q && result.div_error, cmd_q == CMD_NORMAL)
	`ETM_ASSERT_NXT(a_stall_keeps_tail, v_s15 && !adv, v_s15)
	`ETM_ASSERT_NXT(a_col_holds_on_stall, busy_q && !result.ready, col_q == $past(col_q))

endmodule
`default_nettype wire
